[hw/rtl/w65pd_pkg.sv]
package w65pd_pkg;

    localparam int CFG_BITS  = 21;
    localparam int NEXT_BITS = 21;
    localparam logic [CFG_BITS-1:0] MEM_SIZE_RESET = 21'd131072;

    localparam logic [3:0] AM_IMPL = 4'd0;
    localparam logic [3:0] AM_ACCU = 4'd1;
    localparam logic [3:0] AM_IMMD = 4'd2;
    localparam logic [3:0] AM_ZPAG = 4'd3;
    localparam logic [3:0] AM_ZPXI = 4'd4;
    localparam logic [3:0] AM_ZPYI = 4'd5;
    localparam logic [3:0] AM_ABSO = 4'd6;
    localparam logic [3:0] AM_ABSX = 4'd7;
    localparam logic [3:0] AM_ABSY = 4'd8;
    localparam logic [3:0] AM_INDA = 4'd9;
    localparam logic [3:0] AM_INDX = 4'd10;
    localparam logic [3:0] AM_INDY = 4'd11;
    localparam logic [3:0] AM_RELA = 4'd12;
    localparam logic [3:0] AM_ZIND = 4'd13;
    localparam logic [3:0] AM_AIDX = 4'd14;
    localparam logic [3:0] AM_ZREL = 4'd15;

    localparam logic [6:0] MNEM_TAB [256] = '{
        0,1,2,2, 3,1,4,5, 6,1,4,2, 3,1,4,7,
        8,1,1,2, 9,1,4,10, 11,1,12,2, 9,1,4,13,
        14,15,2,2, 16,15,17,18, 19,15,17,2, 16,15,17,20,
        21,15,15,2, 16,15,17,22, 23,15,24,2, 16,15,17,25,
        26,27,2,2, 2,27,28,29, 30,27,28,2, 31,27,28,32,
        33,27,27,2, 2,27,28,34, 35,27,36,2, 2,27,28,37,
        38,39,2,2, 40,39,41,42, 43,39,41,2, 31,39,41,44,
        45,39,39,2, 40,39,41,46, 47,39,48,2, 31,39,41,49,
        50,51,2,2, 52,51,53,54, 55,16,56,2, 52,51,53,57,
        58,51,51,2, 52,51,53,59, 60,51,61,2, 40,51,40,62,
        63,64,65,2, 63,64,65,66, 67,64,68,2, 63,64,65,69,
        70,64,64,2, 63,64,65,71, 72,64,73,2, 63,64,65,74,
        75,76,2,2, 75,76,24,77, 78,76,79,80, 75,76,24,81,
        82,76,76,2, 2,76,24,83, 84,76,85,86, 2,76,24,87,
        88,89,2,2, 88,89,12,90, 91,89,92,2, 88,89,12,93,
        94,89,89,2, 2,89,12,95, 96,89,97,2, 2,89,12,98
    };

    localparam logic [3:0] MODE_TAB [256] = '{
        0,10,2,0, 3,3,3,3, 0,2,1,0, 6,6,6,15,
        12,11,13,0, 3,4,4,3, 0,8,1,0, 6,7,7,15,
        6,10,2,0, 3,3,3,3, 0,2,1,0, 6,6,6,15,
        12,11,13,0, 4,4,4,3, 0,8,1,0, 7,7,7,15,
        0,10,2,0, 3,3,3,3, 0,2,1,0, 6,6,6,15,
        12,11,13,0, 4,4,4,3, 0,8,0,0, 6,7,7,15,
        0,10,2,0, 3,3,3,3, 0,2,1,0, 9,6,6,15,
        12,11,13,0, 4,4,4,3, 0,8,0,0, 14,7,7,15,
        12,10,2,0, 3,3,3,3, 0,2,0,0, 6,6,6,15,
        12,11,13,0, 4,4,5,3, 0,8,0,0, 6,7,7,15,
        2,10,2,0, 3,3,3,3, 0,2,0,0, 6,6,6,15,
        12,11,13,0, 4,4,5,3, 0,8,0,0, 7,7,8,15,
        2,10,2,0, 3,3,3,3, 0,2,0,0, 6,6,6,15,
        12,11,13,0, 4,4,4,3, 0,8,0,0, 6,7,7,15,
        2,10,2,0, 3,3,3,3, 0,2,0,0, 6,6,6,15,
        12,11,13,0, 4,4,4,3, 0,8,0,0, 6,7,7,15
    };

    function automatic logic [1:0] len_of_mode(input logic [3:0] mode);
        logic [1:0] len;
        unique case (mode)
            AM_IMPL, AM_ACCU: len = 2'd1;
            AM_ABSO, AM_ABSX, AM_ABSY, AM_INDA, AM_AIDX, AM_ZREL: len = 2'd3;
            default: len = 2'd2;
        endcase
        return len;
    endfunction

endpackage

[hw/rtl/w65pd_if.sv]
interface w65pd_in_if #(parameter int ADDRESS_BITS = 20);
    logic                    valid;
    logic                    ready;
    logic [ADDRESS_BITS-1:0] address;
    logic [7:0]              opcode_byte;
    logic [7:0]              first_operand_byte;
    logic [7:0]              second_operand_byte;
    modport source (output valid, address, opcode_byte, first_operand_byte,
                    second_operand_byte, input ready);
    modport sink   (input valid, address, opcode_byte, first_operand_byte,
                    second_operand_byte, output ready);
endinterface

interface w65pd_out_if;
    logic        valid;
    logic        ready;
    logic        out_of_range;
    logic [6:0]  mnemonic_code;
    logic [3:0]  addressing_mode;
    logic [1:0]  instruction_length;
    logic [15:0] operand_word;
    logic [15:0] branch_target;
    logic [20:0] next_address;
    modport source (output valid, out_of_range, mnemonic_code, addressing_mode,
                    instruction_length, operand_word, branch_target, next_address,
                    input ready);
    modport sink   (input valid, out_of_range, mnemonic_code, addressing_mode,
                    instruction_length, operand_word, branch_target, next_address,
                    output ready);
endinterface

[hw/rtl/cpu_opcode_predecoder_core.sv]
// channel   dir  payload                                      handshake
// i_in      in   address, opcode and two operand bytes        valid/ready
// o_out     out  decode fields, operand, target, next address valid/ready
// i_cfg     in   memory size register                         i_cfg_we
//
// three register stages; one transfer per cycle sustained while the output is not held
// stage 1: range compares and table lookup; stage 2: operand masking and
// target/next adds; stage 3: output register
// stalls freeze the whole pipe only when every stage is full and the output is held,
// bubbles are squeezed out; nothing is dropped or repeated
// synchronous active-low reset clears valid bits and sets the memory size register to MEM_SIZE_RESET
module cpu_opcode_predecoder_core
    import w65pd_pkg::*;
#(
    parameter int ADDRESS_BITS = 20
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [CFG_BITS-1:0] i_cfg_wdata,
    w65pd_in_if.sink            i_in,
    w65pd_out_if.source         o_out
);

    localparam int WB = (ADDRESS_BITS > CFG_BITS) ? ADDRESS_BITS + 1 : CFG_BITS + 1;

    logic [CFG_BITS-1:0] r_mem_size;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mem_size <= MEM_SIZE_RESET;
        end else if (i_cfg_we) begin
            r_mem_size <= i_cfg_wdata;
        end
    end

    // per-stage valid, advance when the next stage can take
    logic r_v1, r_v2, r_v3;
    logic adv1, adv2, adv3;
    assign adv3 = !r_v3 || o_out.ready;
    assign adv2 = !r_v2 || adv3;
    assign adv1 = !r_v1 || adv2;
    assign i_in.ready = adv1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (adv1) r_v1 <= i_in.valid;
            if (adv2) r_v2 <= r_v1;
            if (adv3) r_v3 <= r_v2;
        end
    end

    // stage 1: compares and lookup
    logic [WB-1:0] addr_w, size_w;
    assign addr_w = WB'(i_in.address);
    assign size_w = WB'(r_mem_size);

    logic [ADDRESS_BITS-1:0] r1_addr;
    logic [7:0]  r1_b1, r1_b2;
    logic        r1_oor, r1_ok1, r1_ok2;
    logic [6:0]  r1_mnem;
    logic [3:0]  r1_mode;

    always_ff @(posedge i_clk) begin
        if (adv1) begin
            r1_addr <= i_in.address;
            r1_b1   <= i_in.first_operand_byte;
            r1_b2   <= i_in.second_operand_byte;
            r1_oor  <= addr_w >= size_w;
            r1_ok1  <= (addr_w + WB'(1)) < size_w;
            r1_ok2  <= (addr_w + WB'(2)) < size_w;
            r1_mnem <= MNEM_TAB[i_in.opcode_byte];
            r1_mode <= MODE_TAB[i_in.opcode_byte];
        end
    end

    // stage 2: masking and adds
    logic [1:0]  len2;
    logic [7:0]  op1, op2;
    logic [15:0] tgt2;
    assign len2 = r1_oor ? 2'd1 : len_of_mode(r1_mode);
    assign op1  = (!r1_oor && len2 >= 2'd2 && r1_ok1) ? r1_b1 : 8'd0;
    assign op2  = (!r1_oor && len2 == 2'd3 && r1_ok2) ? r1_b2 : 8'd0;

    always_comb begin
        tgt2 = 16'd0;
        if (!r1_oor && r1_mode == AM_RELA)
            tgt2 = r1_addr[15:0] + 16'd2 + {{8{op1[7]}}, op1};
        else if (!r1_oor && r1_mode == AM_ZREL)
            tgt2 = r1_addr[15:0] + 16'd3 + {{8{op2[7]}}, op2};
    end

    logic        r2_oor;
    logic [6:0]  r2_mnem;
    logic [3:0]  r2_mode;
    logic [1:0]  r2_len;
    logic [15:0] r2_word, r2_tgt;
    logic [NEXT_BITS-1:0] r2_next;

    always_ff @(posedge i_clk) begin
        if (adv2) begin
            r2_oor  <= r1_oor;
            r2_mnem <= r1_oor ? 7'd0 : r1_mnem;
            r2_mode <= r1_oor ? AM_IMPL : r1_mode;
            r2_len  <= len2;
            r2_word <= {op2, op1};
            r2_tgt  <= tgt2;
            r2_next <= NEXT_BITS'(WB'(r1_addr) + WB'(len2));
        end
    end

    // stage 3: output register
    always_ff @(posedge i_clk) begin
        if (adv3) begin
            o_out.out_of_range       <= r2_oor;
            o_out.mnemonic_code      <= r2_mnem;
            o_out.addressing_mode    <= r2_mode;
            o_out.instruction_length <= r2_len;
            o_out.operand_word       <= r2_word;
            o_out.branch_target      <= r2_tgt;
            o_out.next_address       <= r2_next;
        end
    end
    assign o_out.valid = r_v3;

endmodule

[hw/rtl/w65pd_checker.sv]
module w65pd_checker
    import w65pd_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic        i_out_oor,
    input logic [6:0]  i_out_mnem,
    input logic [3:0]  i_out_mode,
    input logic [1:0]  i_out_len,
    input logic [15:0] i_out_target
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_mnem))
        else $error("output dropped under stall");
    a_oor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_oor |-> i_out_len == 2'd1 && i_out_mnem == 7'd0
            && i_out_target == 16'd0)
        else $error("out of range fields wrong");
    a_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_out_len != 2'd0)
        else $error("zero length");
    a_tgt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_mode != AM_RELA && i_out_mode != AM_ZREL
            |-> i_out_target == 16'd0)
        else $error("target on non-branch");
endmodule

bind cpu_opcode_predecoder_core w65pd_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .i_out_valid(o_out.valid), .i_out_ready(o_out.ready),
    .i_out_oor(o_out.out_of_range), .i_out_mnem(o_out.mnemonic_code),
    .i_out_mode(o_out.addressing_mode), .i_out_len(o_out.instruction_length),
    .i_out_target(o_out.branch_target)
);
